// ===== rtl/core/u8dec_pkg.sv =====
package u8dec_pkg;

  localparam int CP_W    = 21;
  localparam int KIND_W  = 2;
  localparam int OCNT_W  = 16;

  typedef enum logic [2:0] {
    MODE_LEAD = 3'b001,
    MODE_SEQ  = 3'b010,
    MODE_SKIP = 3'b100
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CP  = 2'd0,
    KIND_END = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    kind_t             kind;
    logic [OCNT_W-1:0] count;
  } res_t;

endpackage

// ===== rtl/core/utf8_stream_decoder_core.sv =====
// Streaming UTF-8 style decoder: takes one byte per cycle on the in_ channel and
// returns one code point per finished character on the out_ channel. Every byte
// is decoded in the cycle it is accepted; a character takes one to four bytes and
// its result goes into the result or skid register. A lead with bit 7 set is
// classified by bits 5, 4 and 3 alone and continuation bytes are not checked. A
// NUL lead ends the string with an end-of-string result carrying the saturating
// character count (COUNT_BITS wide, reported clamped to 16 bits). An invalid lead
// yields an error result, after which bytes are dropped silently up to the next
// NUL. A result register plus one skid register let a byte be accepted every
// cycle; in_stall rises only when both hold results the sink has not taken.
module utf8_stream_decoder_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_point,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_char_count
);

  u8dec_pkg::mode_t        mode_r, mode_nxt;
  logic [1:0]              rem_r, rem_nxt;
  logic [u8dec_pkg::CP_W-1:0] acc_r, acc_nxt;
  logic [COUNT_BITS-1:0]   cnt_r, cnt_nxt, cnt_inc;

  u8dec_pkg::res_t         res;
  logic                    res_valid;
  u8dec_pkg::res_t         out_r, out_nxt, skid_r, skid_nxt;
  logic                    out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic                    in_fire, out_fire;
  logic [u8dec_pkg::CP_W-1:0] acc_shift;

  function automatic logic [u8dec_pkg::OCNT_W-1:0] clamp_cnt(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w[31:16] != 16'd0) ? 16'hFFFF : w[15:0];
  endfunction

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid & ~in_stall;
  assign out_fire = out_valid_r & ~out_stall;

  assign cnt_inc   = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
  assign acc_shift = {acc_r[14:0], in_byte[5:0]};

  // per-byte decode
  always_comb begin
    mode_nxt  = mode_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    res       = '{code_point: '0, kind: u8dec_pkg::KIND_CP, count: '0};
    if (in_fire) begin
      case (mode_r)
        u8dec_pkg::MODE_SKIP: begin
          if (in_byte == 8'd0) begin
            cnt_nxt  = '0;
            mode_nxt = u8dec_pkg::MODE_LEAD;
          end
        end
        u8dec_pkg::MODE_SEQ: begin
          if (in_byte == 8'd0) begin
            res_valid = 1'b1;
            res.kind  = u8dec_pkg::KIND_END;
            res.count = clamp_cnt(cnt_r);
            cnt_nxt   = '0;
            acc_nxt   = '0;
            rem_nxt   = 2'd0;
            mode_nxt  = u8dec_pkg::MODE_LEAD;
          end else begin
            acc_nxt = acc_shift;
            rem_nxt = rem_r - 2'd1;
            if (rem_r == 2'd1) begin
              mode_nxt       = u8dec_pkg::MODE_LEAD;
              cnt_nxt        = cnt_inc;
              res_valid      = 1'b1;
              res.code_point = acc_shift;
              res.count      = clamp_cnt(cnt_inc);
            end
          end
        end
        default: begin
          mode_nxt = u8dec_pkg::MODE_LEAD;
          if (in_byte == 8'd0) begin
            res_valid = 1'b1;
            res.kind  = u8dec_pkg::KIND_END;
            res.count = clamp_cnt(cnt_r);
            cnt_nxt   = '0;
          end else if (!in_byte[7]) begin
            cnt_nxt        = cnt_inc;
            res_valid      = 1'b1;
            res.code_point = {13'd0, in_byte};
            res.count      = clamp_cnt(cnt_inc);
          end else if (!in_byte[5]) begin
            acc_nxt  = {16'd0, in_byte[4:0]};
            rem_nxt  = 2'd1;
            mode_nxt = u8dec_pkg::MODE_SEQ;
          end else if (!in_byte[4]) begin
            acc_nxt  = {17'd0, in_byte[3:0]};
            rem_nxt  = 2'd2;
            mode_nxt = u8dec_pkg::MODE_SEQ;
          end else if (!in_byte[3]) begin
            acc_nxt  = {18'd0, in_byte[2:0]};
            rem_nxt  = 2'd3;
            mode_nxt = u8dec_pkg::MODE_SEQ;
          end else begin
            // invalid lead: report, then drop bytes up to nul
            res_valid = 1'b1;
            res.kind  = u8dec_pkg::KIND_ERR;
            res.count = clamp_cnt(cnt_r);
            mode_nxt  = u8dec_pkg::MODE_SKIP;
          end
        end
      endcase
    end
  end

  // result register with skid stage
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= u8dec_pkg::MODE_LEAD;
      rem_r        <= 2'd0;
      acc_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      rem_r        <= rem_nxt;
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = out_r.code_point;
  assign out_result_kind = out_r.kind;
  assign out_char_count  = out_r.count;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while result register is empty");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.kind == u8dec_pkg::KIND_CP || out_r.kind == u8dec_pkg::KIND_END ||
                     out_r.kind == u8dec_pkg::KIND_ERR))
    else $error("illegal result kind");

  a_no_cp_on_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind != u8dec_pkg::KIND_CP) |-> (out_r.code_point == '0))
    else $error("nonzero code point on end or error result");

  a_seq_has_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == u8dec_pkg::MODE_SEQ) |-> (rem_r != 2'd0))
    else $error("in sequence with no continuation bytes due");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_valid_r)
    else $error("decoded transfer lost");

endmodule

// ===== test/utf8_decode_checker.sv =====
module utf8_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [20:0] out_code_point,
  input  logic [1:0]  out_result_kind,
  input  logic [15:0] out_char_count,
  output int          mismatches,
  output int          waiting,
  output int          points_seen,
  output int          ends_seen,
  output int          errors_seen
);

  u8dec_pkg::mode_t dec_mode;
  logic [1:0]       conts_left;
  logic [20:0]      partial_cp;
  logic [15:0]      str_count;
  u8dec_pkg::res_t  decoded_q[$];
  int               bad;
  int               n_points;
  int               n_ends;
  int               n_errors;
  int               n_results;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in result %0d, %s: got 'h%0h, expected 'h%0h", n_results, what, got,
             want);
    bad++;
  endtask

  function automatic void queue_result(input logic [20:0] cp, input u8dec_pkg::kind_t kind);
    u8dec_pkg::res_t r;
    r.code_point = cp;
    r.kind       = kind;
    r.count      = str_count;
    decoded_q.push_back(r);
  endfunction

  function automatic void bump_count();
    if (str_count != 16'hFFFF) str_count++;
  endfunction

  // one byte through the decoder state, results go to decoded_q
  function automatic void decode_byte(input logic [7:0] b);
    case (dec_mode)
      u8dec_pkg::MODE_SKIP: begin
        if (b == 8'h00) begin
          str_count = '0;
          dec_mode  = u8dec_pkg::MODE_LEAD;
        end
      end
      u8dec_pkg::MODE_SEQ: begin
        if (b == 8'h00) begin
          // partial character dropped, string ends
          queue_result('0, u8dec_pkg::KIND_END);
          str_count  = '0;
          partial_cp = '0;
          conts_left = '0;
          dec_mode   = u8dec_pkg::MODE_LEAD;
        end else begin
          partial_cp = {partial_cp[14:0], b[5:0]};
          conts_left = conts_left - 2'd1;
          if (conts_left == 2'd0) begin
            dec_mode = u8dec_pkg::MODE_LEAD;
            bump_count();
            queue_result(partial_cp, u8dec_pkg::KIND_CP);
          end
        end
      end
      default: begin
        dec_mode = u8dec_pkg::MODE_LEAD;
        if (b == 8'h00) begin
          queue_result('0, u8dec_pkg::KIND_END);
          str_count = '0;
        end else if (!b[7]) begin
          bump_count();
          queue_result({13'd0, b}, u8dec_pkg::KIND_CP);
        end else if (!b[5]) begin
          partial_cp = {16'd0, b[4:0]};
          conts_left = 2'd1;
          dec_mode   = u8dec_pkg::MODE_SEQ;
        end else if (!b[4]) begin
          partial_cp = {17'd0, b[3:0]};
          conts_left = 2'd2;
          dec_mode   = u8dec_pkg::MODE_SEQ;
        end else if (!b[3]) begin
          partial_cp = {18'd0, b[2:0]};
          conts_left = 2'd3;
          dec_mode   = u8dec_pkg::MODE_SEQ;
        end else begin
          dec_mode = u8dec_pkg::MODE_SKIP;
          queue_result('0, u8dec_pkg::KIND_ERR);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    u8dec_pkg::res_t want;
    if (!rst_n) begin
      dec_mode   = u8dec_pkg::MODE_LEAD;
      conts_left = '0;
      partial_cp = '0;
      str_count  = '0;
      decoded_q.delete();
      bad       = 0;
      n_points  = 0;
      n_ends    = 0;
      n_errors  = 0;
      n_results = 0;
    end else begin
      // results here come from bytes taken on earlier edges
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_result_kind, 0);
        end else begin
          want = decoded_q.pop_front();
          if (out_result_kind !== want.kind)
            report_mismatch("result_kind", out_result_kind, want.kind);
          if (out_code_point !== want.code_point)
            report_mismatch("code_point", out_code_point, want.code_point);
          if (out_char_count !== want.count)
            report_mismatch("char_count", out_char_count, want.count);
          case (want.kind)
            u8dec_pkg::KIND_CP:  n_points++;
            u8dec_pkg::KIND_END: n_ends++;
            default:             n_errors++;
          endcase
        end
        n_results++;
      end
      if (in_valid && !in_stall) decode_byte(in_byte);
    end
    mismatches  <= bad;
    waiting     <= decoded_q.size();
    points_seen <= n_points;
    ends_seen   <= n_ends;
    errors_seen <= n_errors;
  end

endmodule

// ===== test/tb.sv =====
module tb;

  // short hand-picked strings: extremes, every sequence length, error paths
  localparam logic [7:0] HAND_BYTES [25] = '{
    8'h00, 8'h41, 8'h7F,
    8'hC3, 8'hA9,
    8'hE2, 8'h82, 8'hAC,
    8'hF0, 8'h9F, 8'h98, 8'h80,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'h80, 8'h80,
    8'h00,
    8'hE2, 8'h82, 8'h00,
    8'hFF, 8'h41, 8'h00
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [20:0] out_code_point;
  logic [1:0]  out_result_kind;
  logic [15:0] out_char_count;

  int mismatches;
  int waiting;
  int points_seen;
  int ends_seen;
  int errors_seen;
  int bytes_sent;
  int in_gap_pct;
  int stall_pct;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  utf8_stream_decoder_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_result_kind (out_result_kind),
    .out_char_count  (out_char_count)
  );

  utf8_decode_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_result_kind (out_result_kind),
    .out_char_count  (out_char_count),
    .mismatches      (mismatches),
    .waiting         (waiting),
    .points_seen     (points_seen),
    .ends_seen       (ends_seen),
    .errors_seen     (errors_seen)
  );

  initial begin
    #(12 * 1000000);
    $display("FAIL utf8_stream_decoder_core");
    $finish;
  end

  // sink side: stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // called at a clock edge, returns at the edge where the transfer happened or after the idle gap that follows it
  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    // mostly proper 10xxxxxx, sometimes anything but NUL
    if ($urandom_range(0, 7) != 0) return {2'b10, r[5:0]};
    return (r == 8'h00) ? 8'h5A : r;
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      2:       return {1'b1, r[6], 1'b0, r[4:0]};
      3:       return {1'b1, r[6], 2'b10, r[3:0]};
      4:       return {1'b1, r[6], 3'b110, r[2:0]};
      default: return {1'b0, (r[6:0] == 7'd0) ? 7'd1 : r[6:0]};
    endcase
  endfunction

  task automatic send_char(input bit cut_short);
    int len;
    int conts;
    len   = $urandom_range(1, 4);
    conts = len - 1;
    if (cut_short && len > 1) conts = $urandom_range(0, len - 2);
    send_byte(lead_byte(len));
    repeat (conts) send_byte(cont_byte());
  endtask

  task automatic send_string();
    int nchars;
    int style;
    nchars = $urandom_range(0, 10);
    style  = $urandom_range(0, 9);
    if (style == 0) begin
      // raw noise, NUL included by chance
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat (nchars) send_char(1'b0);
      if (style == 1) begin
        // invalid lead, then junk up to the terminator
        send_byte({1'b1, 1'($urandom), 3'b111, 3'($urandom)});
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(1, 255)));
      end else if (style == 2) begin
        send_char(1'b1);
      end
    end
    send_byte(8'h00);
  endtask

  task automatic random_phase(input int n_bytes, input bit with_idle);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if (with_idle) begin
        in_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
        stall_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      end else begin
        in_gap_pct = 0;
        stall_pct  = 0;
      end
      send_string();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    bytes_sent = 0;
    in_gap_pct = 0;
    stall_pct  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    in_gap_pct = 20;
    stall_pct  = 20;
    foreach (HAND_BYTES[i]) send_byte(HAND_BYTES[i]);

    random_phase(275, 1'b1);
    random_phase(250, 1'b1);

    // no idling on either side toward the end
    random_phase(100, 1'b0);
    in_valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d bytes decoded into %0d code points, %0d string ends, %0d invalid leads",
             bytes_sent, points_seen, ends_seen, errors_seen);
    $display("strings mixed all sequence lengths, cut sequences, bad leads and raw noise");
    if (mismatches == 0 && waiting == 0) begin
      $display("PASS utf8_stream_decoder_core");
    end else begin
      $display("FAIL utf8_stream_decoder_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/u8dec_pkg.sv
rtl/core/utf8_stream_decoder_core.sv
test/utf8_decode_checker.sv
test/tb.sv
